[rtl/mse_pkg.sv]
package mse_pkg;

	localparam int OUT_WIDTH = 18;
	localparam int ROOT_COUNT = 12;
	localparam logic [32:0] DIV10_MUL = 33'd429496730;

	typedef logic [30:0] mant_t;

	function automatic mant_t root_q30(input logic [3:0] k);
		mant_t r;
		case (k)
			4'd0: r = 31'd1518500250;
			4'd1: r = 31'd1276901417;
			4'd2: r = 31'd1170923762;
			4'd3: r = 31'd1121280436;
			4'd4: r = 31'd1097253708;
			4'd5: r = 31'd1085434106;
			4'd6: r = 31'd1079572136;
			4'd7: r = 31'd1076653033;
			4'd8: r = 31'd1075196443;
			4'd9: r = 31'd1074468888;
			4'd10: r = 31'd1074105294;
			4'd11: r = 31'd1073923544;
			default: r = 31'd1073741824;
		endcase
		return r;
	endfunction

endpackage

[rtl/mass_spring_euler_step.sv]
// sequence: a start load passes through ST_O1, ST_O2 and ST_O3 before its result is registered;
// an integration step runs the force, divide, exp2, dt, velocity, position and output states,
// its length set by the one-bit-per-cycle divider and the set bits of the exp2 table index,
// each set bit adding an ST_EXPW wait; ST_O3 holds while the previous result is not taken
// throughput: one item at a time, s_tready is low until the result is registered
// reset: arst_n clears state, position, velocity, the output valid and loads register defaults
module mass_spring_euler_step
	import mse_pkg::*;
#(
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS = 16,
	parameter int EXP_TABLE_BITS = 8,
	localparam int IN_W = ((11 * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((2 * OUT_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// reset_level, start_position, start_velocity, mass_value, gravity_force,
	// spring_stiffness, flow_damping, dry_friction, shove_level, shove_strength, speed_cv
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// position_out, velocity_out
	output logic [OUT_W-1:0] m_tdata
);

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int EB = EXP_TABLE_BITS;
	localparam int FW = 2 * DW + 2;
	localparam int EW = DW + 4;
	localparam int QW = DW + FB;
	localparam int CW = $clog2(QW + 1);
	localparam logic signed [65:0] LIM = 66'sd10 <<< FB;
	localparam logic signed [FW-1:0] SMAX = FW'((66'sd1 <<< (DW - 1)) - 66'sd1);
	localparam logic signed [FW-1:0] SMIN = FW'(-(66'sd1 <<< (DW - 1)));
	localparam logic [62:0] DT_MAX = 63'd1 << 62;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_K     = 5'd1;
	localparam logic [4:0] ST_FL    = 5'd2;
	localparam logic [4:0] ST_FS    = 5'd3;
	localparam logic [4:0] ST_DIV   = 5'd4;
	localparam logic [4:0] ST_EXP   = 5'd5;
	localparam logic [4:0] ST_EXPW  = 5'd6;
	localparam logic [4:0] ST_BASE  = 5'd7;
	localparam logic [4:0] ST_BASEW = 5'd8;
	localparam logic [4:0] ST_V1    = 5'd9;
	localparam logic [4:0] ST_V2    = 5'd10;
	localparam logic [4:0] ST_V3    = 5'd11;
	localparam logic [4:0] ST_P1    = 5'd12;
	localparam logic [4:0] ST_P2    = 5'd13;
	localparam logic [4:0] ST_P3    = 5'd14;
	localparam logic [4:0] ST_O1    = 5'd15;
	localparam logic [4:0] ST_O2    = 5'd16;
	localparam logic [4:0] ST_O3    = 5'd17;

	function automatic logic signed [DW-1:0] clamp(input logic signed [65:0] x);
		logic signed [65:0] r;
		r = (x > LIM) ? LIM : ((x < -LIM) ? -LIM : x);
		return DW'(r);
	endfunction

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
		return x[DW-1] ? DW'(-x) : DW'(x);
	endfunction

	logic [4:0]              state_q;
	logic [31:0]             tick_q;
	logic signed [23:0]      thr_q;
	logic signed [DW-1:0]    pos_q, vel_q, acc_q;
	logic                    init_q, rst_high_q;
	logic signed [DW-1:0]    stiff_q, flow_q;
	logic signed [FW-1:0]    force_q;
	logic signed [EW-1:0]    ip_q;
	logic [EB-1:0]           idx_q;
	logic [3:0]              k_q;
	mant_t                   mant_q;
	logic [62:0]             dt_q;
	logic [DW-1:0]           div_q, rem_q;
	logic [QW-1:0]           dq_q;
	logic [CW-1:0]           cnt_q;
	logic                    neg_q;
	logic [65:0]             tmp_q;
	logic [31:0]             posq_q;
	logic signed [65:0]      p_q;
	logic signed [32:0]      mul_a, mul_b;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	logic signed [DW-1:0] f_rst, f_sp, f_sv, f_mass, f_grav, f_stiff, f_flow, f_fric;
	logic signed [DW-1:0] f_shv, f_shf, f_speed;
	logic signed [32:0]   thr_x;
	logic                 gate_high, load;
	logic signed [EW-1:0] e_val;
	logic signed [FW-1:0] force_base, force_next, fsat;
	logic signed [65:0]   shr;
	logic [DW:0]          div_t;
	logic [DW-1:0]        rem_n;
	logic                 qbit;
	logic [32:0]          base;
	logic [127:0]         wide;
	logic [62:0]          dt_n;
	logic signed [EW-1:0] nip;
	logic [65:0]          rsum;
	logic signed [65:0]   vsum;
	logic [DW-1:0]        vmag;
	logic [17:0]          o_pos, o_vel;

	assign f_rst   = s_tdata[0*DW +: DW];
	assign f_sp    = s_tdata[1*DW +: DW];
	assign f_sv    = s_tdata[2*DW +: DW];
	assign f_mass  = s_tdata[3*DW +: DW];
	assign f_grav  = s_tdata[4*DW +: DW];
	assign f_stiff = s_tdata[5*DW +: DW];
	assign f_flow  = s_tdata[6*DW +: DW];
	assign f_fric  = s_tdata[7*DW +: DW];
	assign f_shv   = s_tdata[8*DW +: DW];
	assign f_shf   = s_tdata[9*DW +: DW];
	assign f_speed = s_tdata[10*DW +: DW];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	assign thr_x = 33'(thr_q);
	assign gate_high = 33'(f_rst) >= thr_x;
	assign load = !init_q || (gate_high && !rst_high_q);
	assign e_val = (EW'(f_speed) <<< 3) + (EW'(f_speed) <<< 1);

	always_comb begin
		force_base = FW'(f_grav);
		if (33'(f_shv) >= thr_x) begin
			force_base = force_base + FW'(f_shf);
		end
		if (vel_q > 0) begin
			force_base = force_base - FW'(f_fric);
		end else if (vel_q < 0) begin
			force_base = force_base + FW'(f_fric);
		end
	end

	assign shr = p_q >>> FB;
	assign force_next = force_q - FW'(shr);
	assign fsat = (force_next > SMAX) ? SMAX : ((force_next < SMIN) ? SMIN : force_next);

	assign div_t = {rem_q, dq_q[QW-1]};
	assign qbit = div_t >= {1'b0, div_q};
	assign rem_n = qbit ? DW'(div_t - {1'b0, div_q}) : DW'(div_t);

	// dt from base mantissa product and the integer exponent
	always_comb begin
		base = 33'(p_q[65:30]);
		nip = -ip_q;
		wide = {95'd0, base} << ip_q[5:0];
		if (base == '0) begin
			dt_n = '0;
		end else if (ip_q < 0) begin
			if (nip >= EW'(64)) begin
				dt_n = '0;
			end else begin
				dt_n = 63'({30'd0, base} >> nip[5:0]);
			end
		end else if (ip_q >= EW'(62) || wide > {65'd0, DT_MAX}) begin
			dt_n = DT_MAX;
		end else begin
			dt_n = wide[62:0];
		end
	end

	assign rsum = 66'(p_q) + tmp_q;
	assign vmag = mag(vel_q);
	assign vsum = (state_q == ST_V3) ?
		(acc_q[DW-1] ? 66'(vel_q) - $signed(rsum) : 66'(vel_q) + $signed(rsum)) :
		(vel_q[DW-1] ? 66'(pos_q) - $signed(rsum) : 66'(pos_q) + $signed(rsum));

	assign o_pos = pos_q[DW-1] ? 18'(-posq_q) : 18'(posq_q);
	assign o_vel = vel_q[DW-1] ? 18'(-p_q[63:32]) : 18'(p_q[63:32]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_K: begin
				mul_a = 33'(stiff_q);
				mul_b = 33'(pos_q);
			end
			ST_FL: begin
				mul_a = 33'(flow_q);
				mul_b = 33'(vel_q);
			end
			ST_EXP: begin
				mul_a = {2'b0, mant_q};
				mul_b = {2'b0, root_q30(k_q)};
			end
			ST_BASE: begin
				mul_a = {1'b0, tick_q};
				mul_b = {2'b0, mant_q};
			end
			ST_V1: begin
				mul_a = {1'b0, 32'(mag(acc_q))};
				mul_b = {1'b0, dt_q[31:0]};
			end
			ST_V2: begin
				mul_a = {1'b0, 32'(mag(acc_q))};
				mul_b = {2'b0, dt_q[62:32]};
			end
			ST_P1: begin
				mul_a = {1'b0, 32'(vmag)};
				mul_b = {1'b0, dt_q[31:0]};
			end
			ST_P2: begin
				mul_a = {1'b0, 32'(vmag)};
				mul_b = {2'b0, dt_q[62:32]};
			end
			ST_O1: begin
				mul_a = {1'b0, 32'(mag(pos_q))};
				mul_b = DIV10_MUL;
			end
			// velocity product held while the result waits
			ST_O2, ST_O3: begin
				mul_a = {1'b0, 32'(vmag)};
				mul_b = DIV10_MUL;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 32'd89478;
			thr_q <= 24'sd6554;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				tick_q <= cfg_data;
			end else begin
				thr_q <= cfg_data[23:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			vel_q <= '0;
			init_q <= 1'b0;
			rst_high_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready && state_q != ST_O3) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						rst_high_q <= gate_high;
						stiff_q <= f_stiff;
						flow_q <= f_flow;
						force_q <= force_base;
						ip_q <= e_val >>> FB;
						idx_q <= e_val[FB-1 -: EB];
						neg_q <= f_mass[DW-1];
						div_q <= (f_mass == '0) ? DW'(1) : mag(f_mass);
						if (load) begin
							init_q <= 1'b1;
							pos_q <= clamp(66'(f_sp) * 66'sd10);
							vel_q <= clamp(66'(f_sv) * 66'sd10);
							state_q <= ST_O1;
						end else begin
							state_q <= ST_K;
						end
					end
				end
				ST_K: state_q <= ST_FL;
				ST_FL: begin
					force_q <= force_next;
					state_q <= ST_FS;
				end
				ST_FS: begin
					neg_q <= neg_q ^ fsat[FW-1];
					rem_q <= '0;
					dq_q <= QW'(fsat[FW-1] ? -fsat : fsat) << FB;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_n;
					dq_q <= {dq_q[QW-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QW - 1)) begin
						k_q <= '0;
						mant_q <= 31'd1 << 30;
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					if (k_q == 4'(EB)) begin
						state_q <= ST_BASE;
					end else if (idx_q[EB-1]) begin
						state_q <= ST_EXPW;
					end else begin
						idx_q <= idx_q << 1;
						k_q <= k_q + 1'b1;
					end
				end
				ST_EXPW: begin
					mant_q <= 31'((p_q + 66'sd536870912) >>> 30);
					idx_q <= idx_q << 1;
					k_q <= k_q + 1'b1;
					state_q <= ST_EXP;
				end
				ST_BASE: begin
					// quotient saturation, done here while the multiplier is busy
					if (!neg_q) begin
						acc_q <= (dq_q > QW'(SMAX)) ? DW'(SMAX) : DW'(dq_q);
					end else begin
						acc_q <= (dq_q > QW'(-SMIN)) ? DW'(SMIN) : DW'(-dq_q);
					end
					state_q <= ST_BASEW;
				end
				ST_BASEW: begin
					dt_q <= dt_n;
					state_q <= ST_V1;
				end
				ST_V1: state_q <= ST_V2;
				ST_V2: begin
					tmp_q <= 66'(p_q[65:32]);
					state_q <= ST_V3;
				end
				ST_V3: begin
					vel_q <= clamp(vsum);
					state_q <= ST_P1;
				end
				ST_P1: state_q <= ST_P2;
				ST_P2: begin
					tmp_q <= 66'(p_q[65:32]);
					state_q <= ST_P3;
				end
				ST_P3: begin
					pos_q <= clamp(vsum);
					state_q <= ST_O1;
				end
				ST_O1: state_q <= ST_O2;
				ST_O2: begin
					posq_q <= p_q[63:32];
					state_q <= ST_O3;
				end
				ST_O3: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q <= OUT_W'({o_vel, o_pos});
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
